// ----- rtl/sawt_pkg.sv -----
`timescale 1ns / 1ps

package sawt_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_FRAME = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Frame marker and frame type codes
  localparam logic [7:0] MARK_OK    = 8'h7E;
  localparam logic [4:0] T_ACK      = 5'h00;
  localparam logic [4:0] T_NACK     = 5'h01;
  localparam logic [4:0] T_LIST     = 5'h0A;
  localparam logic [4:0] T_DOWNLOAD = 5'h0B;
  localparam logic [4:0] T_DATA     = 5'h12;
  localparam logic [4:0] T_EOT      = 5'h1E;
  localparam logic [4:0] T_ERROR    = 5'h1F;

  // Result action codes
  localparam logic [1:0] ACT_RESEND = 2'd0;
  localparam logic [1:0] ACT_ACK    = 2'd1;
  localparam logic [1:0] ACT_DONE   = 2'd2;
  localparam logic [1:0] ACT_ERROR  = 2'd3;

  localparam int SEQ_W        = 5;
  localparam int CFG_W        = 16;
  localparam logic [CFG_W-1:0] BASE_TIMEOUT_RST = 16'd1000;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // One queued command: a single result, or an ack followed by a resend
  typedef struct packed {
    logic             pair;
    logic [1:0]       action;
    logic [SEQ_W-1:0] seq;
  } cmd_t;

  // Queue handshake between the stages
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/sawt_front.sv -----
`timescale 1ns / 1ps

module sawt_front #(
  parameter int TIMER_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [sawt_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          item_acc,
  input  logic [1:0]                    func,
  input  logic [7:0]                    frame_marker,
  input  logic [4:0]                    frame_type,
  input  logic [sawt_pkg::SEQ_W-1:0]    frame_seq,
  output logic                          cmd_push,
  output sawt_pkg::cmd_t                cmd
);

  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  logic [sawt_pkg::CFG_W-1:0] base_timeout_r;
  logic                       waiting_r, waiting_nxt;
  logic [sawt_pkg::SEQ_W-1:0] sent_seq_r, sent_seq_nxt;
  logic                       sent_is_data_r, sent_is_data_nxt;
  logic [TIMER_BITS-1:0]      elapsed_r, elapsed_nxt;
  logic [TIMER_BITS-1:0]      cur_to_r, cur_to_nxt;

  logic frame_ok;
  logic seq_match;
  logic timed_out;
  logic want_ack;

  assign frame_ok  = (frame_marker == sawt_pkg::MARK_OK) && waiting_r;
  assign seq_match = (frame_seq == sent_seq_r);
  assign timed_out = (elapsed_r >= cur_to_r);
  assign want_ack  = (frame_type == sawt_pkg::T_LIST) || (frame_type == sawt_pkg::T_EOT) ||
                     ((frame_type == sawt_pkg::T_DOWNLOAD) && sent_is_data_r);

  // Classify the transaction and compute next state
  always_comb begin
    waiting_nxt      = waiting_r;
    sent_seq_nxt     = sent_seq_r;
    sent_is_data_nxt = sent_is_data_r;
    elapsed_nxt      = elapsed_r;
    cur_to_nxt       = cur_to_r;
    cmd_push         = 1'b0;
    cmd.pair         = 1'b0;
    cmd.action       = sawt_pkg::ACT_RESEND;
    cmd.seq          = '0;
    if (item_acc) begin
      unique case (func)
        sawt_pkg::FUNC_START: begin
          sent_seq_nxt     = frame_seq;
          sent_is_data_nxt = (frame_type == sawt_pkg::T_DATA);
          cur_to_nxt       = TIMER_BITS'(base_timeout_r);
          elapsed_nxt      = '0;
          waiting_nxt      = 1'b1;
        end
        sawt_pkg::FUNC_TICK: begin
          if (waiting_r && (elapsed_r != TMAX)) begin
            elapsed_nxt = elapsed_r + 1'b1;
          end
        end
        sawt_pkg::FUNC_FRAME: begin
          if (frame_ok) begin
            priority if (frame_type == sawt_pkg::T_ERROR) begin
              waiting_nxt = 1'b0;
              cmd_push    = 1'b1;
              cmd.action  = sawt_pkg::ACT_ERROR;
            end else if ((frame_type == sawt_pkg::T_ACK) && seq_match) begin
              waiting_nxt = 1'b0;
              cmd_push    = 1'b1;
              cmd.action  = sawt_pkg::ACT_DONE;
            end else if (timed_out) begin
              // doubling saturates at all ones
              cur_to_nxt  = cur_to_r[TIMER_BITS-1] ? TMAX : {cur_to_r[TIMER_BITS-2:0], 1'b0};
              elapsed_nxt = '0;
              cmd_push    = 1'b1;
            end else if ((frame_type == sawt_pkg::T_NACK) && seq_match) begin
              elapsed_nxt = '0;
              cmd_push    = 1'b1;
            end else if (want_ack) begin
              elapsed_nxt = '0;
              cmd_push    = 1'b1;
              cmd.pair    = 1'b1;
              cmd.action  = sawt_pkg::ACT_ACK;
              cmd.seq     = sent_seq_r - 1'b1;
            end else begin
              cmd_push = 1'b0;
            end
          end
        end
        default: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  // Tracker state and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_timeout_r <= sawt_pkg::BASE_TIMEOUT_RST;
      waiting_r      <= 1'b0;
      sent_seq_r     <= '0;
      sent_is_data_r <= 1'b0;
      elapsed_r      <= '0;
      cur_to_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        base_timeout_r <= cfg_wr_data;
      end
      waiting_r      <= waiting_nxt;
      sent_seq_r     <= sent_seq_nxt;
      sent_is_data_r <= sent_is_data_nxt;
      elapsed_r      <= elapsed_nxt;
      cur_to_r       <= cur_to_nxt;
    end
  end

endmodule

// ----- rtl/sawt_cmdq.sv -----
`timescale 1ns / 1ps

module sawt_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_push,
  input  sawt_pkg::cmd_t    q_wdata,
  input  logic              q_pop,
  output sawt_pkg::cmd_t    q_rdata,
  output sawt_pkg::q_stat_t q_stat
);

  sawt_pkg::cmd_t                mem [sawt_pkg::CMDQ_DEPTH];
  logic [sawt_pkg::CMDQ_AW-1:0]  wr_ptr_r;
  logic [sawt_pkg::CMDQ_AW-1:0]  rd_ptr_r;
  logic [sawt_pkg::CMDQ_AW:0]    count_r;

  assign q_stat.full  = (count_r == (sawt_pkg::CMDQ_AW+1)'(sawt_pkg::CMDQ_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign q_rdata      = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (q_push) begin
      mem[wr_ptr_r] <= q_wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({q_push, q_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- rtl/sawt_back.sv -----
`timescale 1ns / 1ps

module sawt_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sawt_pkg::cmd_t             q_rdata,
  input  logic                       q_empty,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [1:0]                 out_action,
  output logic [sawt_pkg::SEQ_W-1:0] out_ack_seq,
  output logic                       out_last
);

  sawt_pkg::cmd_t cur_r;
  logic           valid_r;
  logic           phase_r;
  logic           take;
  logic           first_of_pair;
  logic           load;

  assign empty         = !valid_r;
  assign take          = pop && valid_r;
  assign first_of_pair = cur_r.pair && !phase_r;
  assign load          = (!valid_r || (take && !first_of_pair)) && !q_empty;
  assign q_pop         = load;

  // Expand the current command into result transactions
  always_comb begin
    if (first_of_pair) begin
      out_action  = sawt_pkg::ACT_ACK;
      out_ack_seq = cur_r.seq;
      out_last    = 1'b0;
    end else begin
      out_action  = cur_r.pair ? sawt_pkg::ACT_RESEND : cur_r.action;
      out_ack_seq = '0;
      out_last    = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (take && first_of_pair) begin
      phase_r <= 1'b1;
    end else if (!valid_r || take) begin
      valid_r <= !q_empty;
      phase_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_rdata;
    end
  end

endmodule

// ----- rtl/stop_and_wait_ack_tracker_core.sv -----
`timescale 1ns / 1ps
// Stop-and-wait acknowledgement tracker, sender side.
// Input channel (push/full): one transaction per cycle while full is low.
//   in_func 0 arms the tracker for a sent frame (type, seq), 1 is a received
//   frame header, 2 is a one-millisecond tick.
// Result channel (empty/pop): the oldest result sits on out_* while empty is
//   low; pop takes it. A frame yields at most two results (ack then resend);
//   out_last marks the final one of a frame.
// Config: cfg_wr_en/cfg_wr_data load base_timeout; write only while idle.
// Timing: one input transaction per cycle while full is low. Decisions are
//   made in the cycle of acceptance from the tracker registers; a result
//   passes the command queue and then the output register. Results drain at
//   one per cycle while pop is high; an ack plus resend needs two pops.
// A 4-entry command queue sits between the decision logic and the output
//   register; when the receiver stalls it fills and full rises, holding the
//   input side. Ticks and starts still need a free entry to be accepted.
// Reset (rst_n low, synchronous): tracker idle, queue and output emptied,
//   base_timeout back to 1000.

module stop_and_wait_ack_tracker_core #(
  parameter int TIMER_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [15:0]                cfg_wr_data,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_func,
  input  logic [7:0]                 in_frame_marker,
  input  logic [4:0]                 in_frame_type,
  input  logic [4:0]                 in_frame_seq,
  output logic                       empty,
  input  logic                       pop,
  output logic [1:0]                 out_action,
  output logic [4:0]                 out_ack_seq,
  output logic                       out_last
);

  logic              item_acc;
  logic              q_push;
  logic              q_pop;
  sawt_pkg::cmd_t    q_wdata;
  sawt_pkg::cmd_t    q_rdata;
  sawt_pkg::q_stat_t q_stat;

  assign full     = q_stat.full;
  assign item_acc = push && !q_stat.full;

  // Decision front end
  sawt_front #(
    .TIMER_BITS (TIMER_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .item_acc     (item_acc),
    .func         (in_func),
    .frame_marker (in_frame_marker),
    .frame_type   (in_frame_type),
    .frame_seq    (in_frame_seq),
    .cmd_push     (q_push),
    .cmd          (q_wdata)
  );

  // Command queue
  sawt_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_stat  (q_stat)
  );

  // Result back end
  sawt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_rdata     (q_rdata),
    .q_empty     (q_stat.empty),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_action  (out_action),
    .out_ack_seq (out_ack_seq),
    .out_last    (out_last)
  );

`ifndef SYNTHESIS
  // An ack result is always followed by its resend
  a_ack_then_resend: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && out_action == sawt_pkg::ACT_ACK) |=>
      (!empty && out_action == sawt_pkg::ACT_RESEND && out_last))
    else $error("ack result not followed by resend");

  // Ack results are never the final result of a frame
  a_ack_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_action == sawt_pkg::ACT_ACK) |-> !out_last)
    else $error("ack result marked last");

  // The queue is never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (item_acc && !q_stat.full))
    else $error("command queue overflow");

  // Starts and ticks never produce results
  a_no_result_on_start_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (item_acc && (in_func == sawt_pkg::FUNC_START || in_func == sawt_pkg::FUNC_TICK))
      |-> !q_push)
    else $error("result queued for start or tick");
`endif

endmodule

// ----- dv/stop_and_wait_ack_tracker_core_test.sv -----
`timescale 1ns / 1ps

module stop_and_wait_ack_tracker_core_test;

  localparam int TIMER_BITS = 32;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS = 205;

  // One input transaction and one result transaction
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] marker;
    logic [4:0] ftype;
    logic [4:0] seq;
  } frame_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] ack_seq;
    logic       last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_func = '0;
  logic [7:0]  in_frame_marker = '0;
  logic [4:0]  in_frame_type = '0;
  logic [4:0]  in_frame_seq = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_action;
  logic [4:0]  out_ack_seq;
  logic        out_last;

  stop_and_wait_ack_tracker_core #(
    .TIMER_BITS(TIMER_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push(push),
    .full(full),
    .in_func(in_func),
    .in_frame_marker(in_frame_marker),
    .in_frame_type(in_frame_type),
    .in_frame_seq(in_frame_seq),
    .empty(empty),
    .pop(pop),
    .out_action(out_action),
    .out_ack_seq(out_ack_seq),
    .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  frame_item_t frame_q[$];   // frames and ticks not yet sent
  reply_t      reply_q[$];   // replies the tracker owes, oldest first
  frame_item_t drv_item;
  logic        in_fire = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          fail_cnt = 0;
  int          cyc = 0;
  int          stim_cnt = 0;

  // Tracker state as the predictor sees it
  logic                  trk_waiting = 1'b0;
  logic [4:0]            trk_sent_seq = '0;
  logic                  trk_sent_data = 1'b0;
  logic [TIMER_BITS-1:0] trk_elapsed = '0;
  logic [TIMER_BITS-1:0] trk_timeout = '0;
  logic [15:0]           trk_base = sawt_pkg::BASE_TIMEOUT_RST;

  // Work out the replies one accepted transaction causes
  function automatic void predict_replies(frame_item_t it);
    if (it.func == sawt_pkg::FUNC_START) begin
      trk_sent_seq = it.seq;
      trk_sent_data = (it.ftype == sawt_pkg::T_DATA);
      trk_timeout = TIMER_BITS'(trk_base);
      trk_elapsed = '0;
      trk_waiting = 1'b1;
    end else if (it.func == sawt_pkg::FUNC_TICK) begin
      if (trk_waiting && trk_elapsed != TIMER_MAX) trk_elapsed = trk_elapsed + 1'b1;
    end else if (it.func == sawt_pkg::FUNC_FRAME && it.marker == sawt_pkg::MARK_OK &&
                 trk_waiting) begin
      if (it.ftype == sawt_pkg::T_ERROR) begin
        trk_waiting = 1'b0;
        reply_q.push_back('{sawt_pkg::ACT_ERROR, 5'd0, 1'b1});
      end else if (it.ftype == sawt_pkg::T_ACK && it.seq == trk_sent_seq) begin
        trk_waiting = 1'b0;
        reply_q.push_back('{sawt_pkg::ACT_DONE, 5'd0, 1'b1});
      end else if (trk_elapsed >= trk_timeout) begin
        // timeout beats all types but error and matching ack; backoff saturates
        trk_timeout = (trk_timeout > (TIMER_MAX >> 1)) ? TIMER_MAX : trk_timeout << 1;
        trk_elapsed = '0;
        reply_q.push_back('{sawt_pkg::ACT_RESEND, 5'd0, 1'b1});
      end else if (it.ftype == sawt_pkg::T_NACK && it.seq == trk_sent_seq) begin
        trk_elapsed = '0;
        reply_q.push_back('{sawt_pkg::ACT_RESEND, 5'd0, 1'b1});
      end else if (it.ftype == sawt_pkg::T_LIST || it.ftype == sawt_pkg::T_EOT ||
                   (it.ftype == sawt_pkg::T_DOWNLOAD && trk_sent_data)) begin
        trk_elapsed = '0;
        reply_q.push_back('{sawt_pkg::ACT_ACK, 5'(trk_sent_seq - 5'd1), 1'b0});
        reply_q.push_back('{sawt_pkg::ACT_RESEND, 5'd0, 1'b1});
      end
    end
  endfunction

  // Driver: next transaction or a sender gap, random pop
  always @(negedge clk) begin
    if (rst_n) begin
      if (!push || in_fire) begin
        if (frame_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_item = frame_q.pop_front();
          in_func <= drv_item.func;
          in_frame_marker <= drv_item.marker;
          in_frame_type <= drv_item.ftype;
          in_frame_seq <= drv_item.seq;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: config shadow, result check, prediction, run limit
  always @(posedge clk) begin
    reply_t exp_r;
    cyc <= cyc + 1;
    if (rst_n) begin
      if (cfg_wr_en) trk_base = cfg_wr_data;
      if (pop && !empty) begin
        if (reply_q.size() == 0) begin
          $error("unexpected result: action %0d ack_seq %0d last %0d",
                 out_action, out_ack_seq, out_last);
          fail_cnt++;
        end else begin
          exp_r = reply_q.pop_front();
          if (out_action !== exp_r.action) begin
            $error("out_action: expected %0d, actual %0d", exp_r.action, out_action);
            fail_cnt++;
          end
          if (out_ack_seq !== exp_r.ack_seq) begin
            $error("out_ack_seq: expected %0d, actual %0d", exp_r.ack_seq, out_ack_seq);
            fail_cnt++;
          end
          if (out_last !== exp_r.last) begin
            $error("out_last: expected %0d, actual %0d", exp_r.last, out_last);
            fail_cnt++;
          end
        end
      end
      if (push && !full) predict_replies('{in_func, in_frame_marker, in_frame_type, in_frame_seq});
      in_fire <= push && !full;
    end
    if (cyc >= CYCLE_LIMIT) begin
      $display("[stop_and_wait_ack_tracker_core] ERROR");
      $finish;
    end
  end

  task automatic add_item(input logic [1:0] f, input logic [7:0] m,
                          input logic [4:0] t, input logic [4:0] s);
    frame_q.push_back('{f, m, t, s});
    stim_cnt++;
  endtask

  // Wait for every transaction to be taken and every reply to be seen
  task automatic wait_drained();
    while (frame_q.size() != 0 || push || reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One wait for a sent frame: start, traffic with random content, then maybe an end
  task automatic queue_session(input int tick_span);
    logic [4:0] sseq;
    logic [4:0] ty;
    int n;
    int r;
    sseq = 5'($urandom);
    add_item(sawt_pkg::FUNC_START, 8'($urandom),
             ($urandom_range(0, 1) != 0) ? sawt_pkg::T_DATA : 5'($urandom), sseq);
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        repeat ($urandom_range(0, tick_span + 2))
          add_item(sawt_pkg::FUNC_TICK, 8'($urandom), 5'($urandom), 5'($urandom));
      end else if (r < 45) begin
        add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_NACK,
                 ($urandom_range(0, 3) != 0) ? sseq : 5'($urandom));
      end else if (r < 60) begin
        case ($urandom_range(0, 2))
          0: ty = sawt_pkg::T_LIST;
          1: ty = sawt_pkg::T_EOT;
          default: ty = sawt_pkg::T_DOWNLOAD;
        endcase
        add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, ty, 5'($urandom));
      end else if (r < 68) begin
        add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_ACK, 5'($urandom));
      end else if (r < 78) begin
        add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, 5'($urandom), 5'($urandom));
      end else if (r < 87) begin
        add_item(sawt_pkg::FUNC_FRAME, 8'($urandom), 5'($urandom), 5'($urandom));
      end else if (r < 92) begin
        add_item(FUNC_NONE, 8'($urandom), 5'($urandom), 5'($urandom));
      end else begin
        // restart the wait with a new frame
        sseq = 5'($urandom);
        add_item(sawt_pkg::FUNC_START, 8'($urandom), 5'($urandom), sseq);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_ACK, sseq);
    end else if (r < 80) begin
      add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_ERROR, 5'($urandom));
    end
    // traffic after an ended wait is dropped by the tracker
    if ($urandom_range(0, 99) < 15) begin
      add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, 5'($urandom), 5'($urandom));
      add_item(sawt_pkg::FUNC_TICK, 8'($urandom), 5'($urandom), 5'($urandom));
    end
  endtask

  initial begin
    int unsigned tmo_vals[8];
    int span;
    tmo_vals = '{0, 1, 65535, 2, 5, 1, 3, 12};
    tmo_vals[4] = $urandom_range(2, 40);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass with the reset timeout
    send_idle_pct = 36;
    recv_idle_pct = 71;
    add_item(FUNC_NONE, 8'hFF, 5'h1F, 5'h1F);
    add_item(sawt_pkg::FUNC_TICK, 8'h00, 5'h00, 5'h00);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_ACK, 5'd0);
    add_item(sawt_pkg::FUNC_START, 8'hFF, sawt_pkg::T_DATA, 5'd0);
    add_item(sawt_pkg::FUNC_FRAME, 8'h00, sawt_pkg::T_ERROR, 5'd0);
    add_item(sawt_pkg::FUNC_FRAME, 8'hFF, sawt_pkg::T_ACK, 5'd0);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_NACK, 5'd0);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_NACK, 5'd1);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_ACK, 5'd31);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_LIST, 5'd5);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_EOT, 5'd0);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_DOWNLOAD, 5'd0);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, 5'h1D, 5'd0);
    add_item(sawt_pkg::FUNC_TICK, 8'hFF, 5'h1F, 5'h1F);
    add_item(sawt_pkg::FUNC_START, 8'h7E, sawt_pkg::T_LIST, 5'd31);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_DOWNLOAD, 5'd31);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_EOT, 5'd0);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_ACK, 5'd31);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_NACK, 5'd31);
    add_item(sawt_pkg::FUNC_START, sawt_pkg::MARK_OK, sawt_pkg::T_DATA, 5'd31);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_ERROR, 5'd31);
    add_item(sawt_pkg::FUNC_START, 8'h00, sawt_pkg::T_ERROR, 5'd16);
    add_item(sawt_pkg::FUNC_FRAME, sawt_pkg::MARK_OK, sawt_pkg::T_ACK, 5'd16);

    // Random phases, one timeout setting each
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= 16'(tmo_vals[p]);
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      @(posedge clk);
      if (p < 2) begin
        send_idle_pct = 36;
        recv_idle_pct = 71;
      end else if (p < 5) begin
        send_idle_pct = 71;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      span = (tmo_vals[p] <= 40) ? int'(tmo_vals[p]) : 4;
      stim_cnt = 0;
      while (stim_cnt < PHASE_ITEMS) queue_session(span);
    end

    wait_drained();
    if (fail_cnt == 0) begin
      $display("[stop_and_wait_ack_tracker_core] OK");
    end else begin
      $display("[stop_and_wait_ack_tracker_core] ERROR");
    end
    $finish;
  end

endmodule
